// ===== src/decimal_seven_segment_shift_driver_defines.svh =====
// Assertion macros for the decimal seven-segment shift driver.
// Depends on nothing; included by the top level only.
`ifndef DECIMAL_SEVEN_SEGMENT_SHIFT_DRIVER_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_SHIFT_DRIVER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define DSSD_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define DSSD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

// ===== src/dssd_pkg.sv =====
// Shared constants and the segment table of the decimal seven-segment shift driver.
// Depends on nothing.
package dssd_pkg;

   localparam int VALUE_WIDTH = 27;
   localparam int QUOT_WIDTH  = 24;   // quotient of a 27-bit value by ten
   localparam int CODE_WIDTH  = 8;
   localparam int POS_WIDTH   = 3;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
   localparam int MAGIC_SHIFT = 30;

   // ceil(2^30 / 10); exact floor division for every 27-bit value
   localparam logic [VALUE_WIDTH-1:0] DIV10_MAGIC = 27'h6666667;

   localparam logic [POS_WIDTH-1:0] LAST_BIT = 3'd7;

   // active-low segment codes, bit 0 goes out first
   function automatic logic [CODE_WIDTH-1:0] seg_code(input logic [3:0] digit);
      logic [CODE_WIDTH-1:0] code;
      unique case (digit)
         4'd0:    code = 8'h03;
         4'd1:    code = 8'h9F;
         4'd2:    code = 8'h25;
         4'd3:    code = 8'h0D;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h49;
         4'd6:    code = 8'h41;
         4'd7:    code = 8'h1F;
         4'd8:    code = 8'h01;
         4'd9:    code = 8'h09;
         default: code = 8'hFF;
      endcase
      return code;
   endfunction

endpackage

// ===== src/dssd_if.sv =====
// Valid/ready channel interfaces for the number input and the serial bit output.
// Depends on dssd_pkg.
interface dssd_req_if;
   import dssd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface dssd_rsp_if;
   import dssd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 seg_bit;
   logic                 latch_pulse;
   logic [POS_WIDTH-1:0] digit_pos;
   logic                 last;

   modport source (output valid, output seg_bit, output latch_pulse, output digit_pos,
                   output last, input ready);
   modport sink   (input valid, input seg_bit, input latch_pulse, input digit_pos,
                   input last, output ready);
endinterface

// ===== src/dssd_div10_cell.sv =====
// One digit cell: divide by ten, map the remainder to a segment code, pass on.
// Depends on dssd_pkg.
module dssd_div10_cell #(
   parameter int DIGIT_COUNT = 8,
   parameter int IDX         = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic [dssd_pkg::VALUE_WIDTH-1:0]          in_num,
   input  logic [DIGIT_COUNT*dssd_pkg::CODE_WIDTH-1:0] in_codes,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [dssd_pkg::VALUE_WIDTH-1:0]          out_num,
   output logic [DIGIT_COUNT*dssd_pkg::CODE_WIDTH-1:0] out_codes
);
   import dssd_pkg::*;

   localparam int CW = DIGIT_COUNT * CODE_WIDTH;

   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0] num_ff, num_in;
   logic [CW-1:0]          codes_ff, codes_in;
   logic [PROD_WIDTH-1:0]  prod;
   logic [QUOT_WIDTH-1:0]  quot;
   logic [VALUE_WIDTH-1:0] ten_quot;
   logic [3:0]             rem;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      prod     = PROD_WIDTH'(in_num) * PROD_WIDTH'(DIV10_MAGIC);
      quot     = prod[MAGIC_SHIFT +: QUOT_WIDTH];
      ten_quot = {quot, 3'b000} + {2'b00, quot, 1'b0};
      rem      = 4'(in_num - ten_quot);
      num_in   = VALUE_WIDTH'(quot);
      codes_in = in_codes;
      codes_in[IDX*CODE_WIDTH +: CODE_WIDTH] = seg_code(rem);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload: hold unless a new transfer lands here
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         num_ff   <= num_in;
         codes_ff <= codes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_codes = codes_ff;
endmodule

// ===== src/dssd_serializer.sv =====
// Serializer: shifts the segment codes out one bit per transfer with digit marks.
// Depends on dssd_pkg and dssd_rsp_if.
module dssd_serializer #(
   parameter int DIGIT_COUNT = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [DIGIT_COUNT*dssd_pkg::CODE_WIDTH-1:0] in_codes,
   dssd_rsp_if.source                                  rsp
);
   import dssd_pkg::*;

   localparam int CW = DIGIT_COUNT * CODE_WIDTH;
   localparam logic [POS_WIDTH-1:0] LAST_DIGIT = POS_WIDTH'(DIGIT_COUNT - 1);

   logic                 busy_ff, busy_in;
   logic [CW-1:0]        shift_ff, shift_in;
   logic [POS_WIDTH-1:0] bit_ff, bit_in;
   logic [POS_WIDTH-1:0] digit_ff, digit_in;
   logic                 end_digit, end_num, xfer, load;

   always_comb begin
      end_digit = (bit_ff == LAST_BIT);
      end_num   = end_digit && (digit_ff == LAST_DIGIT);
      xfer      = busy_ff && rsp.ready;
      in_ready  = !busy_ff || (xfer && end_num);
      load      = in_ready && in_valid;

      busy_in  = busy_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      digit_in = digit_ff;
      priority if (load) begin
         busy_in  = 1'b1;
         shift_in = in_codes;
         bit_in   = '0;
         digit_in = '0;
      end else if (xfer) begin
         shift_in = {1'b0, shift_ff[CW-1:1]};
         bit_in   = bit_ff + 3'd1;
         if (end_digit) begin
            digit_in = digit_ff + 3'd1;
         end
         if (end_num) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         bit_ff   <= '0;
         digit_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         bit_ff   <= bit_in;
         digit_ff <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign rsp.valid       = busy_ff;
   assign rsp.seg_bit     = shift_ff[0];
   assign rsp.latch_pulse = end_digit;
   assign rsp.digit_pos   = digit_ff;
   assign rsp.last        = end_num;
endmodule

// ===== src/decimal_seven_segment_shift_driver.sv =====
// Top level of the decimal seven-segment shift driver: digit cell chain plus serializer.
// Depends on dssd_pkg, dssd_if, dssd_div10_cell, dssd_serializer and the defines header.
//
// Usage:
//   req_if carries one binary number per transfer (value, 27 bits). rsp_if returns
//   DIGIT_COUNT*8 transfers per number, one serial bit each: ones digit first, each
//   digit's segment code least significant bit first. latch_pulse marks the eighth
//   bit of a digit, digit_pos gives its place, last marks the final bit.
//   Values beyond DIGIT_COUNT digits show only their low decimal digits.
//   A DIGIT_COUNT below 1 runs as one digit, one above 8 runs as eight digits.
// Path: a number passes through the register of every digit cell in the chain and
//   is then loaded into the serializer's shift register, which drives its first bit.
// Throughput: one rsp_if transfer per cycle while rsp_if.ready stays high; the
//   serializer's single output bit sets this rate.
//   The cell chain keeps taking numbers while the serializer is still shifting,
//   and a waiting next number's first bit follows the previous last bit with no gap.
// Reset: clears all valid flags and counters; nothing is in flight afterwards.
// Stall: while rsp_if.ready is low the current bit holds; the cell chain fills and
//   then drops req_if.ready until the serializer frees up.
module decimal_seven_segment_shift_driver #(
   parameter int DIGIT_COUNT = 8
) (
   input  logic       clock,
   input  logic       reset,
   dssd_req_if.sink   req_if,
   dssd_rsp_if.source rsp_if
);
   import dssd_pkg::*;
   `include "decimal_seven_segment_shift_driver_defines.svh"

   // clamp the digit count to what the place field can address
   localparam int DIGITS_USED = (DIGIT_COUNT < 1) ? 1 :
                                ((DIGIT_COUNT > (1 << POS_WIDTH)) ? (1 << POS_WIDTH) :
                                 DIGIT_COUNT);
   localparam int CW = DIGITS_USED * CODE_WIDTH;
   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(DIGITS_USED - 1);

   // chain taps: index k feeds cell k, index DIGITS_USED feeds the serializer
   logic                   tap_valid [DIGITS_USED+1];
   logic                   tap_ready [DIGITS_USED+1];
   logic [VALUE_WIDTH-1:0] tap_num   [DIGITS_USED+1];
   logic [CW-1:0]          tap_codes [DIGITS_USED+1];

   assign tap_valid[0]  = req_if.valid;
   assign tap_num[0]    = req_if.value;
   assign tap_codes[0]  = '0;
   assign req_if.ready  = tap_ready[0];

   // one cell per digit; each strips the next decimal digit off the quotient
   for (genvar k = 0; k < DIGITS_USED; k++) begin : g_cell
      dssd_div10_cell #(
         .DIGIT_COUNT (DIGITS_USED),
         .IDX         (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (tap_valid[k]),
         .in_ready  (tap_ready[k]),
         .in_num    (tap_num[k]),
         .in_codes  (tap_codes[k]),
         .out_valid (tap_valid[k+1]),
         .out_ready (tap_ready[k+1]),
         .out_num   (tap_num[k+1]),
         .out_codes (tap_codes[k+1])
      );
   end

   // quotient left after the last cell carries dropped high digits; discard it
   dssd_serializer #(
      .DIGIT_COUNT (DIGITS_USED)
   ) u_serializer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (tap_valid[DIGITS_USED]),
      .in_ready (tap_ready[DIGITS_USED]),
      .in_codes (tap_codes[DIGITS_USED]),
      .rsp      (rsp_if)
   );

   logic unused_quot;
   assign unused_quot = ^tap_num[DIGITS_USED];

   // the final bit of a number always closes a digit in the top place
   `DSSD_ASSERT_IMPL(a_last_latch, clock, reset, rsp_if.valid && rsp_if.last, rsp_if.latch_pulse && (rsp_if.digit_pos == LAST_POS))
   // a bit that is not the final one is always followed by another
   `DSSD_ASSERT_NEXT(a_no_gap, clock, reset, rsp_if.valid && rsp_if.ready && !rsp_if.last, rsp_if.valid)
   // a latch pulse inside a number advances the digit place by one
   `DSSD_ASSERT_NEXT(a_digit_step, clock, reset, rsp_if.valid && rsp_if.ready && rsp_if.latch_pulse && !rsp_if.last, rsp_if.digit_pos == $past(rsp_if.digit_pos) + 3'd1)
   // a new number starts at the ones digit
   `DSSD_ASSERT_NEXT(a_restart, clock, reset, rsp_if.valid && rsp_if.ready && rsp_if.last, !rsp_if.valid || (rsp_if.digit_pos == 3'd0))
endmodule

// ===== bench/decimal_seven_segment_shift_driver_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the decimal seven-segment shift driver: number in, 64 serial bits out.
// Depends on dssd_pkg, the channel interfaces in dssd_if and the driver's top level.
module decimal_seven_segment_shift_driver_tb;
   import dssd_pkg::*;

   localparam int DIGITS        = 8;
   localparam int RANDOM_ITEMS  = 240;
   localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
   localparam int DRAIN_CYCLES  = 4 * DIGITS;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDLE_PERCENT  = 32;

   // Own copy of the active-low segment codes, digits 0 to 9.
   localparam logic [CODE_WIDTH-1:0] SEG_PATTERN [10] = '{
      8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
   };

   // One serial bit as it leaves the driver.
   typedef struct packed {
      logic                 seg_bit;
      logic                 latch_pulse;
      logic [POS_WIDTH-1:0] digit_pos;
      logic                 last;
   } shift_bit_type;

   // Directed stimulus row; where uniform is set, every digit shows uniform_code.
   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      bit                     uniform;
      logic [CODE_WIDTH-1:0]  uniform_code;
   } number_row_type;

   localparam int NUM_ROWS = 20;

   number_row_type directed_rows [NUM_ROWS] = '{
      '{27'd0,         1'b1, 8'h03},   // all zeros, leading zeros kept
      '{27'd11111111,  1'b1, 8'h9F},
      '{27'd22222222,  1'b1, 8'h25},
      '{27'd33333333,  1'b1, 8'h0D},
      '{27'd44444444,  1'b1, 8'h99},
      '{27'd55555555,  1'b1, 8'h49},
      '{27'd66666666,  1'b1, 8'h41},
      '{27'd77777777,  1'b1, 8'h1F},
      '{27'd88888888,  1'b1, 8'h01},
      '{27'd99999999,  1'b1, 8'h09},   // largest value that fits
      '{27'd100000000, 1'b1, 8'h03},   // too large: ninth digit dropped, zeros left
      '{27'h7FFFFFF,   1'b0, 8'h00},   // every value bit set, too large
      '{27'd123456789, 1'b0, 8'h00},   // too large, leading digit dropped
      '{27'h4000000,   1'b0, 8'h00},   // top value bit alone
      '{27'd12345678,  1'b0, 8'h00},
      '{27'd87654321,  1'b0, 8'h00},
      '{27'd1,         1'b0, 8'h00},
      '{27'd9,         1'b0, 8'h00},
      '{27'd10,        1'b0, 8'h00},
      '{27'd90000000,  1'b0, 8'h00}
   };

   logic clock;
   logic reset;

   dssd_req_if req_ch ();
   dssd_rsp_if rsp_ch ();

   decimal_seven_segment_shift_driver #(
      .DIGIT_COUNT(DIGITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // Serial bits still owed by the driver, oldest first.
   shift_bit_type shift_bits_due [$];

   int  error_count  = 0;
   int  cycle_count  = 0;
   bit  hold_off_req = 1'b0;   // sender asks the receiver for one long hold-off
   bit  steady_flow  = 1'b0;   // both sides run without idling

   // 2 ns clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Queue the eight bits of one digit, least significant bit first.
   function automatic void queue_digit_bits(input logic [CODE_WIDTH-1:0] code, input int place);
      shift_bit_type sb;
      for (int b = 0; b < 8; b++) begin
         sb.seg_bit     = code[b];
         sb.latch_pulse = (b == 7);
         sb.digit_pos   = place[POS_WIDTH-1:0];
         sb.last        = (place == DIGITS - 1) && (b == 7);
         shift_bits_due.push_back(sb);
      end
   endfunction

   // Split a number into decimal digits, ones digit first, and queue their segment bits.
   // Digits above DIGITS simply never get looked at, which drops them.
   function automatic void predict_shift_bits(input logic [VALUE_WIDTH-1:0] number);
      logic [VALUE_WIDTH-1:0] rest;
      logic [3:0]             digit;
      rest = number;
      for (int d = 0; d < DIGITS; d++) begin
         digit = 4'(rest % VALUE_WIDTH'(10));
         queue_digit_bits(SEG_PATTERN[digit], d);
         rest = rest / VALUE_WIDTH'(10);
      end
   endfunction

   // Offer one number at the falling edge, with random idle cycles ahead of it,
   // and hold it until the driver takes it at a rising edge.
   task automatic offer_number(input logic [VALUE_WIDTH-1:0] number);
      @(negedge clock);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.value = number;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Wait for every owed bit to come out.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (shift_bits_due.size() != 0) @(posedge clock);
   endtask

   // Receiver: drop ready at random, run steady when asked, and honor one long hold-off.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ch.ready = 1'b0;
            for (int i = 1; i < HOLD_CYCLES; i++) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (steady_flow) begin
            rsp_ch.ready = 1'b1;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Check every serial bit transfer against the oldest owed bit, field by field.
   always @(posedge clock) begin
      shift_bit_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (shift_bits_due.size() == 0) begin
            $display("%0t: unexpected transfer: seg_bit %0b latch_pulse %0b digit_pos %0d last %0b",
                     $time, rsp_ch.seg_bit, rsp_ch.latch_pulse, rsp_ch.digit_pos, rsp_ch.last);
            error_count++;
         end else begin
            want = shift_bits_due.pop_front();
            if (rsp_ch.seg_bit !== want.seg_bit) begin
               $display("%0t: seg_bit expected %0b actual %0b",
                        $time, want.seg_bit, rsp_ch.seg_bit);
               error_count++;
            end
            if (rsp_ch.latch_pulse !== want.latch_pulse) begin
               $display("%0t: latch_pulse expected %0b actual %0b",
                        $time, want.latch_pulse, rsp_ch.latch_pulse);
               error_count++;
            end
            if (rsp_ch.digit_pos !== want.digit_pos) begin
               $display("%0t: digit_pos expected %0d actual %0d",
                        $time, want.digit_pos, rsp_ch.digit_pos);
               error_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $display("%0t: last expected %0b actual %0b",
                        $time, want.last, rsp_ch.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if the driver stops making progress.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("decimal_seven_segment_shift_driver regression: fail");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed table, random numbers, drain, verdict.
   initial begin
      logic [VALUE_WIDTH-1:0] number;
      logic [31:0]            raw;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows: uniform rows carry their code typed in, the rest go through
      // the predictor.
      foreach (directed_rows[i]) begin
         offer_number(directed_rows[i].value);
         if (directed_rows[i].uniform) begin
            for (int d = 0; d < DIGITS; d++) queue_digit_bits(directed_rows[i].uniform_code, d);
         end else begin
            predict_shift_bits(directed_rows[i].value);
         end
      end

      // Pause the sender until the driver has emptied out.
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Start the long hold-off while the sender keeps offering, so the
         // digit chain fills and the driver drops req ready.
         if (n == 40) hold_off_req = 1'b1;
         // Second pause until every owed bit has come out.
         if (n == 120) drain_results();
         // Stretch with no idling on either side.
         steady_flow = (n >= 150) && (n < 200);

         raw = $urandom;
         case ($urandom_range(0, 3))
            0:       number = VALUE_WIDTH'($urandom_range(0, 99999999));
            1:       number = raw[VALUE_WIDTH-1:0];      // includes too-large values
            2:       number = VALUE_WIDTH'($urandom_range(0, 999));    // many leading zeros
            default: number = VALUE_WIDTH'($urandom_range(99990000, 100009999));
         endcase
         offer_number(number);
         predict_shift_bits(number);
      end
      steady_flow = 1'b0;

      drain_results();
      // Let any stray bit surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("decimal_seven_segment_shift_driver regression: pass");
      end else begin
         $display("decimal_seven_segment_shift_driver regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/dssd_pkg.sv
src/dssd_if.sv
src/dssd_div10_cell.sv
src/dssd_serializer.sv
src/decimal_seven_segment_shift_driver.sv
bench/decimal_seven_segment_shift_driver_tb.sv
